[src/mst_pkg.sv]
// Shared types and constants for the minimum spanning tree block.
`default_nettype none
package mst_pkg;

  // Fixed field widths of the channels and the config register
  localparam int VTX_BITS = 6;
  localparam int WIN_BITS = 16;
  localparam int CNT_BITS = 7;
  localparam logic [CNT_BITS-1:0] COUNT_RESET = 7'd64;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_RUN   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Control states
  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_CHK,
    S_ADD_MIRR,
    S_INIT,
    S_SCAN,
    S_PICK,
    S_RELAX,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

endpackage
`default_nettype wire

[src/mst_if.sv]
// Valid/ready channel interfaces for edge commands and parent results.
`default_nettype none
interface mst_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    command;
  logic [mst_pkg::VTX_BITS-1:0]  from_vertex;
  logic [mst_pkg::VTX_BITS-1:0]  to_vertex;
  logic [mst_pkg::WIN_BITS-1:0]  edge_weight;

  modport source (output valid, command, from_vertex, to_vertex, edge_weight, input ready);
  modport sink   (input valid, command, from_vertex, to_vertex, edge_weight, output ready);
endinterface

interface mst_out_if;
  logic                          valid;
  logic                          ready;
  logic [mst_pkg::VTX_BITS-1:0]  vertex;
  logic [mst_pkg::VTX_BITS-1:0]  parent_vertex;
  logic                          reached;
  logic                          last;

  modport source (output valid, vertex, parent_vertex, reached, last, input ready);
  modport sink   (input valid, vertex, parent_vertex, reached, last, output ready);
endinterface
`default_nettype wire

[src/prim_minimum_spanning_tree.sv]
// Top level: edge store, per-vertex store and the Prim sequencer.
//
//  channel   | dir | beat contents
//  ----------+-----+----------------------------------------------------
//  in_ch     | in  | command, from_vertex, to_vertex, edge_weight
//  out_ch    | out | vertex, parent_vertex, reached, last
//  cfg_we/.. | in  | vertex_count, written whenever cfg_we is high
//
//  Add edge: read, compare, write both directions unless an equal or lower weight is stored.
//  Compute: an init sweep, then per tree vertex a scan and a relax
//  through the vertex store read port, then a read and a load per emitted beat.
//  Clear and reset: a sweep over every address of the edge store, no input
//  taken meanwhile.
//  in_ch is ready only between commands; emit waits while out_ch stalls.
`default_nettype none
module prim_minimum_spanning_tree #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mst_pkg::CNT_BITS-1:0]  cfg_wdata,
  mst_in_if.sink                        in_ch,
  mst_out_if.source                     out_ch
);

  localparam int VB  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int W   = WEIGHT_BITS;
  localparam int EW  = W + 1;
  localparam int EAW = 2 * VB;
  localparam int VW  = W + VB + 2;
  localparam logic [63:0] WMAX = (64'd1 << W) - 64'd1;
  localparam logic [VB-1:0] VLAST = VB'(MAX_VERTICES - 1);
  localparam logic [EAW-1:0] ELAST = '1;
  localparam logic [mst_pkg::CNT_BITS-1:0] MAXV = mst_pkg::CNT_BITS'(MAX_VERTICES);

  mst_pkg::state_t state, state_next;

  logic [mst_pkg::CNT_BITS-1:0] vcount;
  logic [VB-1:0]  nlast;
  logic [VB-1:0]  cnt, cnt_next;
  logic           iss, iss_next;
  logic           rd_pend, rd_pend_next;
  logic [VB-1:0]  rd_idx, rd_idx_next;
  logic           found, found_next;
  logic [VB-1:0]  best_idx, best_idx_next;
  logic [W-1:0]   best_key, best_key_next;
  logic [VW-1:0]  best_word, best_word_next;
  logic [EAW-1:0] clr_addr;
  logic [VB-1:0]  ea, eb;
  logic [W-1:0]   ew;
  logic           out_valid, out_load;
  logic [VB-1:0]  out_vtx;
  logic [VB-1:0]  out_par;
  logic           out_reached, out_last;

  // Memory ports
  logic           e_we, e_re;
  logic [EAW-1:0] e_waddr, e_raddr;
  logic [EW-1:0]  e_wdata, e_rdata;
  logic           v_we, v_re;
  logic [VB-1:0]  v_waddr;
  logic [VW-1:0]  v_wdata, v_rdata;

  // Input decode
  logic           accept, add_ok, keep_old, rd_last, cand, emit_go;
  logic [W-1:0]   wsat;
  logic [VB-1:0]  nlast_in;
  logic           v_it, v_kp;
  logic [W-1:0]   v_key;
  logic [VB-1:0]  v_par;

  assign accept = in_ch.valid && in_ch.ready;
  assign add_ok = (7'(in_ch.from_vertex) < MAXV) && (7'(in_ch.to_vertex) < MAXV) &&
                  (in_ch.from_vertex != in_ch.to_vertex);
  assign wsat   = (64'(in_ch.edge_weight) > WMAX) ? W'(WMAX) : W'(in_ch.edge_weight);
  assign nlast_in = (vcount == '0) ? '0 :
                    (vcount >= MAXV) ? VLAST : VB'(vcount - 7'd1);

  assign v_it  = v_rdata[VW-1];
  assign v_kp  = v_rdata[VW-2];
  assign v_key = v_rdata[VB+W-1:VB];
  assign v_par = v_rdata[VB-1:0];

  assign keep_old = e_rdata[W] && (e_rdata[W-1:0] <= ew);
  assign rd_last  = rd_pend && (rd_idx == nlast);
  assign cand     = rd_pend && !v_it && v_kp && (!found || (v_key < best_key));
  assign emit_go  = !out_valid || out_ch.ready;

  mst_ram #(.AW(EAW), .DW(EW)) u_edge (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );

  mst_ram #(.AW(VB), .DW(VW)) u_vert (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .re(v_re), .raddr(cnt), .rdata(v_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mst_pkg::S_CLEAR: begin
        if (clr_addr == ELAST) state_next = mst_pkg::S_IDLE;
      end
      mst_pkg::S_IDLE: begin
        if (accept) begin
          if (in_ch.command == mst_pkg::CMD_ADD && add_ok) state_next = mst_pkg::S_ADD_CHK;
          else if (in_ch.command == mst_pkg::CMD_RUN) state_next = mst_pkg::S_INIT;
          else if (in_ch.command == mst_pkg::CMD_CLEAR) state_next = mst_pkg::S_CLEAR;
        end
      end
      mst_pkg::S_ADD_CHK: begin
        state_next = keep_old ? mst_pkg::S_IDLE : mst_pkg::S_ADD_MIRR;
      end
      mst_pkg::S_ADD_MIRR: state_next = mst_pkg::S_IDLE;
      mst_pkg::S_INIT: begin
        if (cnt == nlast) state_next = mst_pkg::S_SCAN;
      end
      mst_pkg::S_SCAN: begin
        if (rd_last) state_next = mst_pkg::S_PICK;
      end
      mst_pkg::S_PICK: begin
        if (found) state_next = mst_pkg::S_RELAX;
        else if (nlast == '0) state_next = mst_pkg::S_IDLE;
        else state_next = mst_pkg::S_EMIT_RD;
      end
      mst_pkg::S_RELAX: begin
        if (rd_last) state_next = mst_pkg::S_SCAN;
      end
      mst_pkg::S_EMIT_RD: state_next = mst_pkg::S_EMIT_LD;
      mst_pkg::S_EMIT_LD: begin
        if (emit_go) state_next = (cnt == nlast) ? mst_pkg::S_IDLE : mst_pkg::S_EMIT_RD;
      end
      default: state_next = mst_pkg::S_IDLE;
    endcase
  end

  // Memory controls and datapath next values
  always_comb begin
    e_we = 1'b0;
    e_waddr = clr_addr;
    e_wdata = '0;
    e_re = 1'b0;
    e_raddr = {in_ch.from_vertex[VB-1:0], in_ch.to_vertex[VB-1:0]};
    v_we = 1'b0;
    v_waddr = cnt;
    v_wdata = '0;
    v_re = 1'b0;
    cnt_next = cnt;
    iss_next = iss;
    rd_pend_next = 1'b0;
    rd_idx_next = rd_idx;
    found_next = found;
    best_idx_next = best_idx;
    best_key_next = best_key;
    best_word_next = best_word;
    out_load = 1'b0;
    case (state)
      mst_pkg::S_CLEAR: begin
        e_we = 1'b1;
      end
      mst_pkg::S_IDLE: begin
        e_re = accept && (in_ch.command == mst_pkg::CMD_ADD);
        cnt_next = '0;
      end
      mst_pkg::S_ADD_CHK: begin
        e_we = !keep_old;
        e_waddr = {ea, eb};
        e_wdata = {1'b1, ew};
      end
      mst_pkg::S_ADD_MIRR: begin
        e_we = 1'b1;
        e_waddr = {eb, ea};
        e_wdata = {1'b1, ew};
      end
      mst_pkg::S_INIT: begin
        v_we = 1'b1;
        v_wdata = {1'b0, (cnt == '0), W'(0), VB'(0)};
        if (cnt == nlast) begin
          cnt_next = '0;
          iss_next = 1'b1;
          found_next = 1'b0;
        end else begin
          cnt_next = cnt + VB'(1);
        end
      end
      mst_pkg::S_SCAN, mst_pkg::S_RELAX: begin
        // issue one read per cycle, evaluate the entry in the next cycle
        e_raddr = {best_idx, cnt};
        if (iss) begin
          v_re = 1'b1;
          e_re = (state == mst_pkg::S_RELAX);
          rd_pend_next = 1'b1;
          rd_idx_next = cnt;
          if (cnt == nlast) iss_next = 1'b0;
          else cnt_next = cnt + VB'(1);
        end
        if (state == mst_pkg::S_SCAN) begin
          if (cand) begin
            found_next = 1'b1;
            best_idx_next = rd_idx;
            best_key_next = v_key;
            best_word_next = v_rdata;
          end
        end else begin
          // strict less-than relaxation of the new tree vertex's neighbors
          v_waddr = rd_idx;
          v_wdata = {1'b0, 1'b1, e_rdata[W-1:0], best_idx};
          v_we = rd_pend && e_rdata[W] && !v_it &&
                 (!v_kp || (e_rdata[W-1:0] < v_key));
          if (rd_last) begin
            cnt_next = '0;
            iss_next = 1'b1;
            found_next = 1'b0;
          end
        end
      end
      mst_pkg::S_PICK: begin
        v_waddr = best_idx;
        v_wdata = {1'b1, best_word[VW-2:0]};
        v_we = found;
        cnt_next = found ? '0 : VB'(1);
        iss_next = found;
      end
      mst_pkg::S_EMIT_RD: begin
        v_re = 1'b1;
      end
      mst_pkg::S_EMIT_LD: begin
        if (emit_go) begin
          out_load = 1'b1;
          cnt_next = cnt + VB'(1);
        end
      end
      default: begin
        cnt_next = cnt;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mst_pkg::S_CLEAR;
      clr_addr  <= '0;
      vcount    <= mst_pkg::COUNT_RESET;
      iss       <= 1'b0;
      rd_pend   <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      iss     <= iss_next;
      rd_pend <= rd_pend_next;
      found   <= found_next;
      if (state == mst_pkg::S_CLEAR) clr_addr <= clr_addr + EAW'(1);
      if (cfg_we) vcount <= cfg_wdata;
      if (out_load) out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    rd_idx    <= rd_idx_next;
    best_idx  <= best_idx_next;
    best_key  <= best_key_next;
    best_word <= best_word_next;
    if (accept) begin
      ea <= in_ch.from_vertex[VB-1:0];
      eb <= in_ch.to_vertex[VB-1:0];
      ew <= wsat;
      nlast <= nlast_in;
    end
    if (out_load) begin
      out_vtx     <= cnt;
      out_par     <= v_it ? v_par : '0;
      out_reached <= v_it;
      out_last    <= (cnt == nlast);
    end
  end

  assign in_ch.ready          = (state == mst_pkg::S_IDLE);
  assign out_ch.valid         = out_valid;
  assign out_ch.vertex        = mst_pkg::VTX_BITS'(out_vtx);
  assign out_ch.parent_vertex = mst_pkg::VTX_BITS'(out_par);
  assign out_ch.reached       = out_reached;
  assign out_ch.last          = out_last;

  // Checks
  a_pick_relax: assert property (@(posedge clk) disable iff (rst)
    (state == mst_pkg::S_PICK && found) |=> (state == mst_pkg::S_RELAX))
    else $error("found vertex not relaxed");

  a_edge_wr: assert property (@(posedge clk) disable iff (rst)
    e_we |-> (state == mst_pkg::S_CLEAR || state == mst_pkg::S_ADD_CHK ||
              state == mst_pkg::S_ADD_MIRR))
    else $error("edge store written outside load or clear");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == mst_pkg::S_IDLE) |-> (!rd_pend && !iss))
    else $error("read pipeline busy in idle");

  a_rd_range: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (rd_idx <= nlast))
    else $error("vertex read beyond count");

endmodule
`default_nettype wire

[src/mst_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none
module mst_ram #(
  parameter int AW = 1,
  parameter int DW = 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[verif/mst_tb_if.sv]
// Testbench copy point: channel interfaces come from the RTL; this file holds beat types.
`timescale 1ns / 100ps
package mst_tb_pkg;

  // One input beat
  typedef struct packed {
    mst_pkg::cmd_t                  command;
    logic [mst_pkg::VTX_BITS-1:0]   from_vertex;
    logic [mst_pkg::VTX_BITS-1:0]   to_vertex;
    logic [mst_pkg::WIN_BITS-1:0]   edge_weight;
  } edge_cmd_t;

  // One parent report beat
  typedef struct packed {
    logic [mst_pkg::VTX_BITS-1:0]   vertex;
    logic [mst_pkg::VTX_BITS-1:0]   parent_vertex;
    logic                           reached;
    logic                           last;
  } parent_beat_t;
endpackage

[verif/prim_minimum_spanning_tree_test.sv]
// Self-checking testbench for the Prim minimum spanning tree block.
`timescale 1ns / 100ps
module prim_minimum_spanning_tree_test;

  localparam int NV = 64;
  localparam logic [16:0] HAS_EDGE = 17'h10000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [mst_pkg::CNT_BITS-1:0] cfg_wdata = '0;

  mst_in_if  in_ch ();
  mst_out_if out_ch ();

  prim_minimum_spanning_tree u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [16:0]                    weight_grid [NV][NV];
  logic [mst_pkg::CNT_BITS-1:0]   count_reg;
  mst_tb_pkg::parent_beat_t       parents_due[$];
  int                             mismatches = 0;
  bit                             calm = 1'b0;   // no idling in the last part

  // Prim from vertex 0 over the active vertices; queue the parent beats
  task automatic predict_tree();
    logic [16:0] key [NV];
    logic [5:0]  par [NV];
    bit          joined [NV];
    int          n, best, u;
    logic [16:0] e;
    mst_tb_pkg::parent_beat_t pb;
    n = (count_reg < 1) ? 1 : (count_reg > NV) ? NV : count_reg;
    for (int v = 0; v < n; v++) begin
      key[v] = '0; par[v] = '0; joined[v] = 1'b0;
    end
    key[0] = HAS_EDGE;
    forever begin
      best = -1;
      for (int v = 0; v < n; v++)
        if (!joined[v] && key[v][16])
          if (best < 0 || key[v][15:0] < key[best][15:0]) best = v;
      if (best < 0) break;
      u = best;
      joined[u] = 1'b1;
      for (int v = 0; v < n; v++) begin
        e = weight_grid[u][v];
        if (e[16] && !joined[v] && (!key[v][16] || e[15:0] < key[v][15:0])) begin
          key[v] = e; par[v] = u[5:0];
        end
      end
    end
    for (int v = 1; v < n; v++) begin
      pb.vertex = v[5:0];
      pb.parent_vertex = joined[v] ? par[v] : '0;
      pb.reached = joined[v];
      pb.last = (v + 1 == n);
      parents_due = {parents_due, pb};
    end
  endtask

  task automatic apply_cmd(mst_tb_pkg::edge_cmd_t c);
    logic [5:0] a, b;
    a = c.from_vertex; b = c.to_vertex;
    case (c.command)
      mst_pkg::CMD_ADD: begin
        if (a != b && !(weight_grid[a][b][16] && weight_grid[a][b][15:0] <= c.edge_weight)) begin
          weight_grid[a][b] = HAS_EDGE | c.edge_weight;
          weight_grid[b][a] = HAS_EDGE | c.edge_weight;
        end
      end
      mst_pkg::CMD_RUN:   predict_tree();
      mst_pkg::CMD_CLEAR: foreach (weight_grid[i, j]) weight_grid[i][j] = '0;
      default: ;
    endcase
  endtask

  // Send one command beat with optional leading idle burst
  task automatic send_cmd(mst_tb_pkg::edge_cmd_t c);
    if (!calm && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(13, 1)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= c.command;
    in_ch.from_vertex <= c.from_vertex;
    in_ch.to_vertex   <= c.to_vertex;
    in_ch.edge_weight <= c.edge_weight;
    do @(posedge clk); while (!in_ch.ready);
    apply_cmd(c);
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (parents_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_count(int c);
    drain();
    repeat (5000) @(negedge clk);  // any compute with no result still finishing
    cfg_we <= 1'b1; cfg_wdata <= c[mst_pkg::CNT_BITS-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    count_reg = c[mst_pkg::CNT_BITS-1:0];
  endtask

  function automatic mst_tb_pkg::edge_cmd_t mk(mst_pkg::cmd_t c, int a, int b, int w);
    mst_tb_pkg::edge_cmd_t r;
    r.command = c; r.from_vertex = a[5:0]; r.to_vertex = b[5:0]; r.edge_weight = w[15:0];
    return r;
  endfunction

  // Result checker
  mst_tb_pkg::parent_beat_t got, want;
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.vertex, out_ch.parent_vertex, out_ch.reached, out_ch.last};
      if (parents_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", got);
      end else begin
        want = parents_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("parent mismatch exp %p got %p", want, got);
        end
      end
    end
  end

  // Sink stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(13, 1)) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Directed table: extremes, every command, special cases
  mst_tb_pkg::edge_cmd_t dir_rows[$];

  initial begin
    mst_tb_pkg::edge_cmd_t c;
    int n;
    in_ch.valid = 1'b0; in_ch.command = mst_pkg::CMD_NONE;
    in_ch.from_vertex = '0; in_ch.to_vertex = '0; in_ch.edge_weight = '0;
    foreach (weight_grid[i, j]) weight_grid[i][j] = '0;
    count_reg = mst_pkg::COUNT_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset count 64, empty graph: all unreached
    send_cmd(mk(mst_pkg::CMD_RUN, 0, 0, 0));
    set_count(1);
    send_cmd(mk(mst_pkg::CMD_RUN, 0, 0, 0));          // single vertex, no beats
    set_count(0);
    send_cmd(mk(mst_pkg::CMD_RUN, 0, 0, 0));          // zero acts as one
    set_count(127);                                   // above max acts as 64
    dir_rows = '{mk(mst_pkg::CMD_ADD, 0, 63, 16'hFFFF), mk(mst_pkg::CMD_ADD, 63, 0, 5),
                 mk(mst_pkg::CMD_ADD, 5, 5, 1), mk(mst_pkg::CMD_ADD, 0, 1, 0),
                 mk(mst_pkg::CMD_ADD, 1, 2, 7), mk(mst_pkg::CMD_ADD, 0, 2, 7),
                 mk(mst_pkg::CMD_ADD, 2, 0, 9), mk(mst_pkg::CMD_NONE, 42, 21, 16'hAAAA),
                 mk(mst_pkg::CMD_ADD, 42, 21, 16'h5555), mk(mst_pkg::CMD_RUN, 63, 63, 0)};
    foreach (dir_rows[i]) send_cmd(dir_rows[i]);
    set_count(3);                                     // edge to 63 now beyond count
    send_cmd(mk(mst_pkg::CMD_RUN, 0, 0, 0));
    send_cmd(mk(mst_pkg::CMD_CLEAR, 0, 0, 0));
    send_cmd(mk(mst_pkg::CMD_RUN, 0, 0, 0));
    // expected typed in: empty graph at count 3
    if (parents_due.size() != 2 ||
        parents_due[1] !== mst_tb_pkg::parent_beat_t'{6'd2, 6'd0, 1'b0, 1'b1}) begin
      mismatches++;
      if (mismatches <= 10) $display("empty graph prediction off");
    end
    set_count(2);

    // Random phases: mostly small counts, one large
    for (int ph = 0; ph < 8; ph++) begin
      n = (ph == 3) ? 64 : (ph == 6) ? 2 : $urandom_range(12, 2);
      if (ph == 7) calm = 1'b1;
      set_count(n);
      send_cmd(mk(mst_pkg::CMD_CLEAR, 0, 0, 0));
      for (int k = 0; k < 15; k++) begin
        case ($urandom_range(19))
          0: c = mk(mst_pkg::CMD_NONE, $urandom, $urandom, $urandom);
          1: c = mk(mst_pkg::CMD_ADD, $urandom_range(63), $urandom_range(63), $urandom);
          2: c = mk(mst_pkg::CMD_RUN, $urandom, $urandom, $urandom);
          default: c = mk(mst_pkg::CMD_ADD, $urandom_range(n - 1), $urandom_range(n - 1),
                          ($urandom_range(1)) ? $urandom_range(7) : $urandom);
        endcase
        send_cmd(c);
      end
      send_cmd(mk(mst_pkg::CMD_RUN, 0, 0, 0));
      if (ph == 2) begin
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (parents_due.size() != 0);
      end
    end
    drain();
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule
